// File: rtl/tcs_pkg.sv
// Shared types, constants and decode helpers for the text chunk splitter.
// No dependencies; used by tcs_front, tcs_queue, tcs_back and the top level.
package tcs_pkg;

  localparam int OFS_W  = 17;
  localparam int CODE_W = 21;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [OFS_W-1:0] BUF_BYTES = OFS_W'(65536);

  // chunk_type codes
  localparam logic [2:0] CT_BYTE = 3'd0;
  localparam logic [2:0] CT_CHAR = 3'd1;
  localparam logic [2:0] CT_ITEM = 3'd2;
  localparam logic [2:0] CT_LINE = 3'd3;
  localparam logic [2:0] CT_WORD = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_CHUNK_TYPE = 2'd0;
  localparam logic [1:0] REG_ITEM_DELIM = 2'd1;

  localparam logic [CODE_W-1:0] DELIM_RESET = CODE_W'(44);

  localparam logic [7:0] LEAD4_TAG = 8'h1e;
  localparam logic [7:0] LEAD3_TAG = 8'h0e;
  localparam logic [7:0] LEAD2_TAG = 8'h06;
  localparam logic [7:0] LEAD4_MASK = 8'hf0;
  localparam logic [7:0] LEAD3_MASK = 8'he0;
  localparam logic [7:0] LEAD2_MASK = 8'hc0;
  localparam logic [7:0] CONT_MASK  = 8'h80;

  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SP = 8'h20;

  typedef struct packed {
    logic [OFS_W-1:0] off;
    logic [OFS_W-1:0] len;
    logic [OFS_W-1:0] rs;
    logic [OFS_W-1:0] re;
  } res_t;

  // one queue entry: the results of one item, one or two of them
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [OFS_W-1:0]  byte_offset;
    logic [OFS_W-1:0]  char_count;
    logic [OFS_W-1:0]  chunk_start;
    logic [OFS_W-1:0]  sequence_start;
    logic [1:0]        bytes_remaining;
    logic [CODE_W-1:0] code_accum;
    logic              in_word;
    logic              seen_first;
  } bstate_t;

  typedef struct packed {
    bstate_t st;
    logic    emit;
    res_t    r;
  } cd_t;

  // continuation bytes that follow a lead byte
  function automatic logic [1:0] lead_rem(logic [7:0] b);
    logic [1:0] rem;
    rem = 2'd0;
    if ((b >> 3) == LEAD4_TAG) rem = 2'd3;
    else if ((b >> 4) == LEAD3_TAG) rem = 2'd2;
    else if ((b >> 5) == LEAD2_TAG) rem = 2'd1;
    return rem;
  endfunction

  function automatic logic [7:0] lead_mask(logic [1:0] rem);
    logic [7:0] m;
    case (rem)
      2'd3: m = LEAD4_MASK;
      2'd2: m = LEAD3_MASK;
      2'd1: m = LEAD2_MASK;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  function automatic logic is_space(logic [CODE_W-1:0] c);
    return c == {13'b0, CH_SP} || c == {13'b0, CH_TAB} ||
           c == {13'b0, CH_CR} || c == {13'b0, CH_LF};
  endfunction

  // character finished at byte_offset; trunc marks one cut off by the buffer end
  function automatic cd_t char_done(bstate_t s, logic trunc, logic [2:0] ct,
                                    logic [CODE_W-1:0] dlm);
    cd_t o;
    logic delim;
    logic ws;
    o.st = s;
    o.emit = 1'b0;
    o.r = '0;
    o.st.char_count = s.char_count + OFS_W'(1);
    if (ct == CT_ITEM) delim = (s.code_accum == dlm);
    else delim = (s.code_accum == {13'b0, CH_LF}) || (s.code_accum == {13'b0, CH_CR});
    ws = !trunc && is_space(s.code_accum);
    case (ct)
      CT_CHAR: begin
        o.emit = 1'b1;
        o.r = '{off: s.sequence_start, len: s.byte_offset - s.sequence_start,
                rs: o.st.char_count, re: o.st.char_count};
      end
      CT_ITEM, CT_LINE: begin
        if (!trunc && delim) begin
          o.emit = 1'b1;
          o.r = '{off: s.chunk_start, len: s.sequence_start - s.chunk_start,
                  rs: s.chunk_start, re: s.sequence_start};
          o.st.chunk_start = s.byte_offset;
        end
      end
      CT_WORD: begin
        if (!s.seen_first) begin
          o.st.seen_first = 1'b1;
          o.st.in_word = !ws;
        end else if (ws && s.in_word) begin
          o.st.in_word = 1'b0;
          o.emit = 1'b1;
          o.r = '{off: s.chunk_start, len: s.sequence_start - s.chunk_start,
                  rs: s.chunk_start, re: s.sequence_start};
        end else if (!ws && !s.in_word) begin
          o.st.in_word = 1'b1;
          o.st.chunk_start = s.sequence_start;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

endpackage

// File: rtl/tcs_front.sv
// Front end: configuration registers, byte decode and chunk bookkeeping.
// Each accepted item pushes at most one entry of up to two results. Uses tcs_pkg.
module tcs_front import tcs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        byte_value,
  input  logic              has_byte,
  input  logic              last_byte,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [CODE_W-1:0] cfg_data,
  input  q_stat_t           q_stat,
  output logic              push,
  output entry_t            push_entry
);

  logic [2:0]        chunk_type;
  logic [CODE_W-1:0] item_delimiter;
  bstate_t           st;
  bstate_t           st_next;

  logic [OFS_W-1:0] pos;
  logic [1:0]       rem;
  logic [1:0]       n;
  logic             take;
  logic             done;
  cd_t              cd_byte;
  cd_t              cd_trunc;
  res_t             rl [2];

  assign in_ready = !q_stat.full;

  always_comb begin
    st_next = st;
    n = 2'd0;
    rl[0] = '0;
    rl[1] = '0;
    pos = st.byte_offset;
    rem = 2'd0;
    done = 1'b0;
    cd_byte = '0;
    cd_trunc = '0;
    take = has_byte && (st.byte_offset < BUF_BYTES);
    if (take) begin
      st_next.byte_offset = pos + OFS_W'(1);
      if (chunk_type == CT_BYTE) begin
        rl[0] = '{off: pos, len: OFS_W'(1), rs: pos, re: pos};
        n = 2'd1;
      end
      if (st.bytes_remaining == 2'd0) begin
        rem = lead_rem(byte_value);
        st_next.sequence_start = pos;
        st_next.code_accum = {13'b0, byte_value ^ lead_mask(rem)};
        st_next.bytes_remaining = rem;
        done = (rem == 2'd0);
      end else begin
        st_next.code_accum = (st.code_accum << 6) | {13'b0, byte_value ^ CONT_MASK};
        st_next.bytes_remaining = st.bytes_remaining - 2'd1;
        done = (st_next.bytes_remaining == 2'd0);
      end
      if (done) begin
        cd_byte = char_done(st_next, 1'b0, chunk_type, item_delimiter);
        st_next = cd_byte.st;
        if (cd_byte.emit) begin
          rl[n[0]] = cd_byte.r;
          n = n + 2'd1;
        end
      end
    end
    if (last_byte) begin
      if (st_next.bytes_remaining != 2'd0) begin
        st_next.bytes_remaining = 2'd0;
        cd_trunc = char_done(st_next, 1'b1, chunk_type, item_delimiter);
        st_next = cd_trunc.st;
        if (cd_trunc.emit) begin
          rl[n[0]] = cd_trunc.r;
          n = n + 2'd1;
        end
      end
      if (chunk_type == CT_ITEM || chunk_type == CT_LINE ||
          (chunk_type == CT_WORD && (!st_next.seen_first || st_next.in_word))) begin
        rl[n[0]] = '{off: st_next.chunk_start,
                     len: st_next.byte_offset - st_next.chunk_start,
                     rs: st_next.chunk_start, re: st_next.byte_offset};
        n = n + 2'd1;
      end
      st_next = '0;
    end
  end

  assign push = in_valid && in_ready && (n != 2'd0);
  assign push_entry = '{two: n == 2'd2, r0: rl[0], r1: rl[1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (in_valid && in_ready) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_type <= CT_BYTE;
      item_delimiter <= DELIM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CHUNK_TYPE: chunk_type <= cfg_data[2:0];
        REG_ITEM_DELIM: item_delimiter <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/tcs_queue.sv
// Short entry queue between front and back end.
// Holds per-item result groups; uses tcs_pkg.
module tcs_queue import tcs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  entry_t  push_entry,
  input  logic    pop,
  output entry_t  head,
  output q_stat_t q_stat
);

  entry_t            mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign q_stat.full  = (count == (QPTR_W + 1)'(QDEPTH));
  assign q_stat.empty = (count == '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop) count <= count + (QPTR_W + 1)'(1);
      else if (pop && !push) count <= count - (QPTR_W + 1)'(1);
    end
  end

endmodule

// File: rtl/tcs_back.sv
// Back end: plays out the queue head one result per ready cycle and
// marks the last result of each item. Uses tcs_pkg.
module tcs_back import tcs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  entry_t           head,
  input  q_stat_t          q_stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OFS_W-1:0] chunk_offset,
  output logic [OFS_W-1:0] chunk_length,
  output logic [OFS_W-1:0] report_start,
  output logic [OFS_W-1:0] report_end,
  output logic             last_result
);

  logic sub;   // second result of the head entry is on the port
  logic sub_next;
  res_t cur;

  assign out_valid = !q_stat.empty;
  assign cur = sub ? head.r1 : head.r0;
  assign last_result = sub || !head.two;
  assign chunk_offset = cur.off;
  assign chunk_length = cur.len;
  assign report_start = cur.rs;
  assign report_end = cur.re;
  assign pop = out_valid && out_ready && last_result;

  always_comb begin
    sub_next = sub;
    if (out_valid && out_ready) sub_next = !last_result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= 1'b0;
    end else begin
      sub <= sub_next;
    end
  end

endmodule

// File: rtl/text_chunk_splitter_unit.sv
// Text chunk splitter, top level: front end, entry queue and back end.
// Depends on tcs_pkg, tcs_front, tcs_queue, tcs_back.
//
// Usage: bytes of a UTF-8 buffer enter on in_valid/in_ready with has_byte and
// last_byte; chunks leave on out_valid/out_ready, one item per result, with
// last_result on the final result of each input item. An input item with
// last_byte closes the buffer and clears the offsets for the next one.
// chunk_type and item_delimiter are written over cfg_write/cfg_index/cfg_data
// while no buffer item is in flight.
//
// Throughput: one input item per cycle while in_ready is high. The front end
// decodes each byte and updates all counters in the cycle it is accepted. Each
// result is one output transfer, so an item that yields two results (a
// delimiter and the final chunk) holds the output for both of them.
// Results are registered in the entry queue and presented from its head.
// A four-entry queue between front and back lets the sender keep going while
// the receiver stalls; in_ready drops only when the queue is full.
// Reset (rst, synchronous) empties the queue, clears all buffer state and
// restores chunk_type to byte mode and item_delimiter to a comma.
module text_chunk_splitter_unit import tcs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        byte_value,
  input  logic              has_byte,
  input  logic              last_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OFS_W-1:0]  chunk_offset,
  output logic [OFS_W-1:0]  chunk_length,
  output logic [OFS_W-1:0]  report_start,
  output logic [OFS_W-1:0]  report_end,
  output logic              last_result,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [CODE_W-1:0] cfg_data
);

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  entry_t  push_entry;
  entry_t  head;

  tcs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_value (byte_value),
    .has_byte   (has_byte),
    .last_byte  (last_byte),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  tcs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  tcs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_stat       (q_stat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .chunk_offset (chunk_offset),
    .chunk_length (chunk_length),
    .report_start (report_start),
    .report_end   (report_end),
    .last_result  (last_result)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  // the first of two results is always followed by its partner
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_result |=> out_valid)
    else $error("second result of an item missing");

endmodule

// File: sim/testbench.sv
// Self-checking testbench for text_chunk_splitter_unit: directed and random byte
// streams in every chunk mode, each chunk checked against an in-bench predictor.
// Depends on rtl/tcs_pkg.sv and the splitter RTL under rtl/.
module testbench;
  import tcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;

  // chunk types with no defined behavior
  localparam logic [2:0] CT_UNDEF_LO = 3'd5;
  localparam logic [2:0] CT_UNDEF_HI = 3'd7;

  typedef logic [7:0] text_t[$];
  typedef enum logic [1:0] {LEAVE_OPEN, END_ON_LAST, END_MARKER} finish_e;

  typedef struct packed {
    logic [OFS_W-1:0] off;
    logic [OFS_W-1:0] len;
    logic [OFS_W-1:0] rs;
    logic [OFS_W-1:0] re;
    logic             last;
  } chunk_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        byte_value;
  logic              has_byte;
  logic              last_byte;
  logic              out_valid;
  logic              out_ready;
  logic [OFS_W-1:0]  chunk_offset;
  logic [OFS_W-1:0]  chunk_length;
  logic [OFS_W-1:0]  report_start;
  logic [OFS_W-1:0]  report_end;
  logic              last_result;
  logic              cfg_write;
  logic [1:0]        cfg_index;
  logic [CODE_W-1:0] cfg_data;

  // predictor copy of registers and buffer state
  logic [2:0]        m_type;
  logic [CODE_W-1:0] m_delim;
  logic [OFS_W-1:0]  p_ofs;
  logic [OFS_W-1:0]  p_chars;
  logic [OFS_W-1:0]  p_chunk;
  logic [OFS_W-1:0]  p_seq;
  logic [1:0]        p_rem;
  logic [CODE_W-1:0] p_code;
  logic              p_inword;
  logic              p_seen;

  chunk_t chunks_due[$];
  text_t  gen_text;

  int errors = 0;
  int items_sent = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int noise_pct = 0;
  bit hold_req = 0;
  int hold_left = 0;

  text_chunk_splitter_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .byte_value(byte_value), .has_byte(has_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .chunk_offset(chunk_offset), .chunk_length(chunk_length),
    .report_start(report_start), .report_end(report_end),
    .last_result(last_result),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  task automatic clear_buffer();
    p_ofs = '0;
    p_chars = '0;
    p_chunk = '0;
    p_seq = '0;
    p_rem = '0;
    p_code = '0;
    p_inword = 1'b0;
    p_seen = 1'b0;
  endtask

  task automatic add_chunk(input logic [OFS_W-1:0] off, len, rs, re);
    chunks_due.push_back('{off: off, len: len, rs: rs, re: re, last: 1'b0});
  endtask

  // a character ends at the current offset; trunc marks one cut off by the end
  task automatic close_char(input logic trunc);
    logic [OFS_W-1:0] fin;
    logic delim;
    logic ws;
    fin = p_ofs;
    p_chars = p_chars + 1'b1;
    ws = !trunc && (p_code == CODE_W'(CH_SP) || p_code == CODE_W'(CH_TAB) ||
                    p_code == CODE_W'(CH_CR) || p_code == CODE_W'(CH_LF));
    case (m_type)
      CT_CHAR: add_chunk(p_seq, fin - p_seq, p_chars, p_chars);
      CT_ITEM, CT_LINE: begin
        if (m_type == CT_ITEM) delim = (p_code == m_delim);
        else delim = (p_code == CODE_W'(CH_LF)) || (p_code == CODE_W'(CH_CR));
        if (!trunc && delim) begin
          add_chunk(p_chunk, p_seq - p_chunk, p_chunk, p_seq);
          p_chunk = fin;
        end
      end
      CT_WORD: begin
        if (!p_seen) begin
          p_seen = 1'b1;
          p_inword = !ws;
        end else if (ws && p_inword) begin
          p_inword = 1'b0;
          add_chunk(p_chunk, p_seq - p_chunk, p_chunk, p_seq);
        end else if (!ws && !p_inword) begin
          p_inword = 1'b1;
          p_chunk = p_seq;
        end
      end
      default: ;
    endcase
  endtask

  task automatic predict_item(input logic [7:0] b, input logic has, input logic last);
    logic [OFS_W-1:0] pos;
    logic done;
    int before_cnt;
    chunk_t c;
    before_cnt = chunks_due.size();
    if (has && p_ofs < BUF_BYTES) begin
      pos = p_ofs;
      p_ofs = pos + 1'b1;
      if (m_type == CT_BYTE) add_chunk(pos, OFS_W'(1), pos, pos);
      if (p_rem == 2'd0) begin
        p_seq = pos;
        if ((b >> 3) == LEAD4_TAG) begin
          p_code = CODE_W'(b ^ LEAD4_MASK);
          p_rem = 2'd3;
        end else if ((b >> 4) == LEAD3_TAG) begin
          p_code = CODE_W'(b ^ LEAD3_MASK);
          p_rem = 2'd2;
        end else if ((b >> 5) == LEAD2_TAG) begin
          p_code = CODE_W'(b ^ LEAD2_MASK);
          p_rem = 2'd1;
        end else begin
          p_code = CODE_W'(b);
          p_rem = 2'd0;
        end
        done = (p_rem == 2'd0);
      end else begin
        // continuation bytes are taken as they come, unchecked
        p_code = {p_code[CODE_W-7:0], 6'b0} | CODE_W'(b ^ CONT_MASK);
        p_rem = p_rem - 1'b1;
        done = (p_rem == 2'd0);
      end
      if (done) close_char(1'b0);
    end
    if (last) begin
      pos = p_ofs;
      if (p_rem != 2'd0) begin
        p_rem = 2'd0;
        close_char(1'b1);
      end
      if (m_type == CT_ITEM || m_type == CT_LINE)
        add_chunk(p_chunk, pos - p_chunk, p_chunk, pos);
      else if (m_type == CT_WORD && (!p_seen || p_inword))
        add_chunk(p_chunk, pos - p_chunk, p_chunk, pos);
      clear_buffer();
    end
    if (chunks_due.size() > before_cnt) begin
      c = chunks_due.pop_back();
      c.last = 1'b1;
      chunks_due.push_back(c);
    end
  endtask

  // ---------------------------------------------------------------- checker

  task automatic check_field(input string name, input logic [OFS_W-1:0] want, got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    chunk_t want;
    if (rst) begin
      m_type = CT_BYTE;
      m_delim = DELIM_RESET;
      clear_buffer();
    end else begin
      if (out_valid && out_ready) begin
        if (chunks_due.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected chunk: offset %0d length %0d start %0d end %0d",
                   $time, chunk_offset, chunk_length, report_start, report_end);
        end else begin
          want = chunks_due.pop_front();
          check_field("chunk_offset", want.off, chunk_offset);
          check_field("chunk_length", want.len, chunk_length);
          check_field("report_start", want.rs, report_start);
          check_field("report_end", want.re, report_end);
          check_field("last_result", OFS_W'(want.last), OFS_W'(last_result));
        end
      end
      // an item taken at this edge still sees the old register values
      if (in_valid && in_ready) predict_item(byte_value, has_byte, last_byte);
      if (cfg_write) begin
        case (cfg_index)
          REG_CHUNK_TYPE: m_type = cfg_data[2:0];
          REG_ITEM_DELIM: m_delim = cfg_data;
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_item(input logic [7:0] b, input logic has, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    byte_value = b;
    has_byte = has;
    last_byte = last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (has || last) items_sent++;
  endtask

  task automatic send_text(input text_t txt, input finish_e how);
    int i;
    for (i = 0; i < txt.size(); i++) begin
      if ($urandom_range(99) < noise_pct) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(txt[i], 1'b1, how == END_ON_LAST && i == txt.size() - 1);
    end
    if (how == END_MARKER || (how == END_ON_LAST && txt.size() == 0))
      send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    in_valid = 1'b0;
    while (chunks_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [CODE_W-1:0] val);
    wait_quiet();
    cfg_index = idx;
    cfg_data = val;
    cfg_write = 1'b1;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic append_char(input logic [CODE_W-1:0] cp);
    if (cp >= CODE_W'(21'h10000)) begin
      gen_text.push_back(LEAD4_MASK | 8'(cp[20:18]));
      gen_text.push_back(CONT_MASK | 8'(cp[17:12]));
      gen_text.push_back(CONT_MASK | 8'(cp[11:6]));
      gen_text.push_back(CONT_MASK | 8'(cp[5:0]));
    end else if (cp >= CODE_W'(21'h800)) begin
      gen_text.push_back(LEAD3_MASK | 8'(cp[15:12]));
      gen_text.push_back(CONT_MASK | 8'(cp[11:6]));
      gen_text.push_back(CONT_MASK | 8'(cp[5:0]));
    end else if (cp >= CODE_W'(21'h80)) begin
      gen_text.push_back(LEAD2_MASK | 8'(cp[10:6]));
      gen_text.push_back(CONT_MASK | 8'(cp[5:0]));
    end else begin
      gen_text.push_back(cp[7:0]);
    end
  endtask

  // words, white space, delimiters and UTF-8, now and then a cut-off tail
  task automatic build_text(input int n);
    int i;
    int pick;
    int cont;
    logic [7:0] lead;
    gen_text.delete();
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        gen_text.push_back(8'($urandom_range(8'h7a, 8'h61)));
      end else if (pick < 55) begin
        case ($urandom_range(3))
          0: gen_text.push_back(CH_SP);
          1: gen_text.push_back(CH_TAB);
          2: gen_text.push_back(CH_CR);
          default: gen_text.push_back(CH_LF);
        endcase
      end else if (pick < 68) begin
        append_char(m_delim);
      end else if (pick < 80) begin
        append_char(CODE_W'($urandom) >> $urandom_range(13));
      end else if (pick < 92) begin
        gen_text.push_back(8'($urandom_range(255)));
      end else begin
        gen_text.push_back(8'h2c);
      end
    end
    if ($urandom_range(99) < 15) begin
      case ($urandom_range(2))
        0: begin lead = LEAD2_MASK | 8'($urandom_range(31)); cont = 0; end
        1: begin lead = LEAD3_MASK | 8'($urandom_range(15)); cont = $urandom_range(1); end
        default: begin lead = LEAD4_MASK | 8'($urandom_range(7)); cont = $urandom_range(2); end
      endcase
      gen_text.push_back(lead);
      repeat (cont) gen_text.push_back(CONT_MASK | 8'($urandom_range(63)));
    end
  endtask

  // chunk type value, sometimes with junk above the register width
  function automatic logic [CODE_W-1:0] random_type();
    logic [CODE_W-1:0] v;
    v = CODE_W'($urandom);
    if ($urandom_range(1) == 0) v[CODE_W-1:3] = '0;
    if ($urandom_range(9) == 0) v[2:0] = 3'($urandom_range(CT_UNDEF_HI, CT_UNDEF_LO));
    else v[2:0] = 3'($urandom_range(CT_WORD, CT_BYTE));
    return v;
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_reset_defaults();
    send_text('{8'h00, 8'hff}, END_ON_LAST);
    set_reg(REG_CHUNK_TYPE, CODE_W'(CT_ITEM));
    send_text('{8'h61, 8'h2c, 8'h62}, END_ON_LAST);
  endtask

  task automatic test_char_decode();
    set_reg(REG_CHUNK_TYPE, CODE_W'(CT_CHAR));
    // two-byte, widest four-byte, unchecked continuation, cut-off tail
    send_text('{8'hc3, 8'ha9, 8'hf7, 8'hbf, 8'hbf, 8'hbf, 8'hc3, 8'h41,
                8'he2, 8'h82}, END_ON_LAST);
  endtask

  task automatic test_item_line();
    set_reg(REG_ITEM_DELIM, 21'h1fffff);
    send_text('{8'h61, 8'hf7, 8'hbf, 8'hbf, 8'hbf, 8'h2c}, END_ON_LAST);
    // cut-off lead byte decodes to the delimiter but must not split
    set_reg(REG_ITEM_DELIM, 21'h2);
    send_text('{8'h78, 8'he2}, END_ON_LAST);
    set_reg(REG_CHUNK_TYPE, CODE_W'(CT_LINE));
    send_text('{CH_CR, 8'h61, CH_LF}, END_ON_LAST);
  endtask

  task automatic test_word_split();
    set_reg(REG_CHUNK_TYPE, CODE_W'(CT_WORD));
    send_text('{CH_SP, 8'h61, CH_TAB, 8'h62, 8'he2}, END_ON_LAST);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'ha5, 1'b0, 1'b1);
    send_text('{8'h61, CH_LF}, END_MARKER);
  endtask

  task automatic test_undefined_and_switch();
    set_reg(REG_CHUNK_TYPE, CODE_W'(CT_UNDEF_HI));
    send_text('{8'h61, CH_SP}, END_ON_LAST);
    set_reg(REG_CHUNK_TYPE, CODE_W'(CT_BYTE));
    send_text('{8'h61, 8'h62}, LEAVE_OPEN);
    set_reg(REG_CHUNK_TYPE, CODE_W'(CT_CHAR));
    send_text('{8'hc3, 8'ha9}, END_ON_LAST);
  endtask

  task automatic test_backpressure();
    int i;
    set_reg(REG_CHUNK_TYPE, CODE_W'(CT_BYTE));
    @(posedge clk);
    hold_req = 1'b1;
    for (i = 0; i < 40; i++) send_item(8'($urandom_range(255)), 1'b1, i == 39);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
    int target;
    int len;
    logic [CODE_W-1:0] dlm;
    finish_e how;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    noise_pct = 5;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(99) < 30) set_reg(REG_CHUNK_TYPE, random_type());
      if ($urandom_range(99) < 15) begin
        case ($urandom_range(5))
          0: dlm = CODE_W'($urandom_range(127));
          1: dlm = '0;
          2: dlm = '1;
          3: dlm = CODE_W'($urandom);
          4: dlm = CODE_W'(CH_LF);
          default: dlm = CODE_W'($urandom_range(16'hffff));
        endcase
        set_reg(REG_ITEM_DELIM, dlm);
      end
      // chunk type switch in the middle of a buffer
      if ($urandom_range(9) == 0) begin
        build_text($urandom_range(8, 1));
        send_text(gen_text, LEAVE_OPEN);
        set_reg(REG_CHUNK_TYPE, random_type());
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10);
      how = ($urandom_range(99) < 70) ? END_ON_LAST : END_MARKER;
      build_text(len);
      send_text(gen_text, how);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    byte_value = '0;
    has_byte = 1'b0;
    last_byte = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_CHUNK_TYPE;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_char_decode();
    test_item_line();
    test_word_split();
    test_undefined_and_switch();
    test_backpressure();
    test_random_traffic(0, 0, 150);
    test_random_traffic(87, 0, 150);
    test_random_traffic(0, 87, 150);
    test_random_traffic(28, 28, 150);

    wait_quiet();
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: text_chunk_splitter_unit.f
rtl/tcs_pkg.sv
rtl/tcs_front.sv
rtl/tcs_queue.sv
rtl/tcs_back.sv
rtl/text_chunk_splitter_unit.sv
sim/testbench.sv
